// ===== rtl/sfr_pkg.sv =====
// Shared types and constants for the streaming find-and-replace block.
// No dependencies; every other file imports this package.
package sfr_pkg;

	// Longest pattern the match window can hold
	localparam int MAX_WORD = 8;
	// Replacement bytes and results per item are bounded by the 64-bit register
	localparam int REP_MAX  = 8;
	localparam int FILL_W   = $clog2(MAX_WORD + 1);
	localparam int CNT_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 64;

	// Command queue between front and back
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       out_last;
	} out_item_t;

	// One emit command: up to REP_MAX bytes, byte 0 in the low bits.
	// A command with count zero is a bare end marker and always has last set.
	typedef struct packed {
		logic [8*REP_MAX-1:0] bytes;
		logic [CNT_W-1:0]     count;
		logic                 last;
	} cmd_t;

	// Queue read side as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

// ===== rtl/sfr_front.sv =====
// Front end: configuration registers, match window and classification of each item.
// Depends on sfr_pkg; pushes one emit command per item that produces output.
module sfr_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              accept,
	input  sfr_pkg::in_item_t                 item,
	output logic                              push,
	output sfr_pkg::cmd_t                     cmd
);
	import sfr_pkg::*;

	logic [63:0]        pattern_q;
	logic [3:0]         plen_raw_q;
	logic [63:0]        rep_q;
	logic [3:0]         rlen_raw_q;

	logic [7:0]         win_q [MAX_WORD];
	logic [FILL_W-1:0]  fill_q;

	logic [7:0]         wnext [MAX_WORD];
	logic [3:0]         plen_c;
	logic [FILL_W-1:0]  plen;
	logic [CNT_W-1:0]   rlen;
	logic [FILL_W-1:0]  fill_inc;
	logic               full;
	logic               hit;
	logic [MAX_WORD-1:0] match;
	logic [8*REP_MAX-1:0] wword;

	// Clamp lengths into range
	always_comb begin
		if (plen_raw_q == 4'd0)
			plen_c = 4'd1;
		else if (plen_raw_q > 4'(MAX_WORD))
			plen_c = 4'(MAX_WORD);
		else
			plen_c = plen_raw_q;
		plen = FILL_W'(plen_c);
		rlen = (rlen_raw_q > 4'(REP_MAX)) ? CNT_W'(REP_MAX) : CNT_W'(rlen_raw_q);
	end

	// Insert the new byte and compare the window against the pattern
	always_comb begin
		wword = '0;
		for (int k = 0; k < MAX_WORD; k++) begin
			wnext[k] = (fill_q == FILL_W'(k)) ? item.in_byte : win_q[k];
			match[k] = (FILL_W'(k) >= plen) || (wnext[k] == pattern_q[8*k +: 8]);
			wword[8*k +: 8] = wnext[k];
		end
		fill_inc = fill_q + FILL_W'(1);
		full     = (fill_inc == plen);
		hit      = full && (&match);
	end

	// Classify: replacement, window flush, oldest byte, or nothing
	always_comb begin
		cmd.last  = item.in_last;
		cmd.bytes = wword;
		cmd.count = '0;
		if (hit) begin
			cmd.bytes = rep_q;
			cmd.count = rlen;
		end else if (item.in_last) begin
			cmd.count = CNT_W'(fill_inc);
		end else if (full) begin
			cmd.count = CNT_W'(1);
		end
		push = accept && ((cmd.count != '0) || item.in_last);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q  <= '0;
			plen_raw_q <= 4'd1;
			rep_q      <= '0;
			rlen_raw_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PATTERN_BYTES:      pattern_q  <= cfg_data;
				REG_PATTERN_LENGTH:     plen_raw_q <= cfg_data[3:0];
				REG_REPLACEMENT_BYTES:  rep_q      <= cfg_data;
				REG_REPLACEMENT_LENGTH: rlen_raw_q <= cfg_data[3:0];
			endcase
		end
	end

	// Window fill count; a new pattern length drops pending bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cfg_valid && (cfg_index == REG_PATTERN_LENGTH)) begin
			fill_q <= '0;
		end else if (accept) begin
			if (hit || item.in_last)
				fill_q <= '0;
			else if (full)
				fill_q <= plen - FILL_W'(1);
			else
				fill_q <= fill_inc;
		end
	end

	// Window bytes: shift out the oldest on a miss, otherwise keep the insert
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < MAX_WORD; k++) begin
				if (full && !hit)
					win_q[k] <= (k + 1 < MAX_WORD) ? wnext[(k + 1) % MAX_WORD] : wnext[k];
				else
					win_q[k] <= wnext[k];
			end
		end
	end

endmodule

// ===== rtl/sfr_queue.sv =====
// Short command queue between the front and back ends.
// Depends on sfr_pkg for the command type and depth.
module sfr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sfr_pkg::cmd_t    push_cmd,
	input  logic             pop,
	output logic             full,
	output sfr_pkg::q_head_t head
);
	import sfr_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !do_pop)
				count_q <= count_q + QCNT_W'(1);
			else if (!push && do_pop)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	// Store commands
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== rtl/sfr_back.sv =====
// Back end: expands queued commands into result items, one per cycle unless result_stall holds them.
// Depends on sfr_pkg; drives the registered result channel.
module sfr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sfr_pkg::q_head_t   head,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output sfr_pkg::out_item_t result_item
);
	import sfr_pkg::*;

	logic [8*REP_MAX-1:0] cur_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 last_q;
	logic                 valid_q;
	out_item_t            item_q;

	logic                 advance;
	logic                 active;

	assign advance      = !valid_q || !result_stall;
	assign active       = (cnt_q != '0);
	assign pop          = advance && !active && head.valid;
	assign result_valid = valid_q;
	assign result_item  = item_q;

	// Control: output valid and remaining byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (advance) begin
			if (active) begin
				valid_q <= 1'b1;
				cnt_q   <= cnt_q - CNT_W'(1);
			end else if (head.valid) begin
				valid_q <= 1'b1;
				cnt_q   <= (head.cmd.count == '0) ? '0 : head.cmd.count - CNT_W'(1);
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// Payload: emit the next byte, or an end marker for an empty command
	always_ff @(posedge clk) begin
		if (advance) begin
			if (active) begin
				item_q.out_byte   <= cur_q[7:0];
				item_q.byte_valid <= 1'b1;
				item_q.out_last   <= last_q && (cnt_q == CNT_W'(1));
				cur_q             <= cur_q >> 8;
			end else if (head.valid) begin
				last_q <= head.cmd.last;
				cur_q  <= head.cmd.bytes >> 8;
				if (head.cmd.count == '0) begin
					item_q.out_byte   <= '0;
					item_q.byte_valid <= 1'b0;
					item_q.out_last   <= 1'b1;
				end else begin
					item_q.out_byte   <= head.cmd.bytes[7:0];
					item_q.byte_valid <= 1'b1;
					item_q.out_last   <= head.cmd.last && (head.cmd.count == CNT_W'(1));
				end
			end
		end
	end

endmodule

// ===== rtl/stream_find_replace_all.sv =====
// Streaming find-and-replace-all on a byte stream.
// Throughput: one text item per cycle while the command queue is not full; one
// result per cycle while result_stall is low, so an item that expands to N results
// (N up to 8) holds the back end, and the 4-entry command queue absorbs the
// difference. Reset clears window, queue and output; configuration returns to
// pattern length 1, replacement length 0.
module stream_find_replace_all (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           text_valid,
	output logic                           text_stall,
	input  sfr_pkg::in_item_t              text_item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output sfr_pkg::out_item_t             result_item
);
	import sfr_pkg::*;

	logic     accept;
	logic     push;
	cmd_t     cmd;
	logic     q_full;
	q_head_t  head;
	logic     pop;

	assign cfg_ready  = 1'b1;
	assign text_stall = q_full;
	assign accept     = text_valid && !text_stall;

	// Classify incoming text
	sfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (text_item),
		.push      (push),
		.cmd       (cmd)
	);

	// Decouple front and back
	sfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (cmd),
		.pop      (pop),
		.full     (q_full),
		.head     (head)
	);

	// Expand commands into result items
	sfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	// A bare end marker always closes the text
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_item.byte_valid |-> result_item.out_last)
		else $error("end marker without last flag");

	// A bare end marker carries a zero byte
	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_item.byte_valid |-> result_item.out_byte == 8'd0)
		else $error("end marker with nonzero byte");

	// Every queued command leaves room: a push never meets a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("command queue overflow");

endmodule

// ===== verif/stream_find_replace_all_test.sv =====
`timescale 1ns / 1ps
// Testbench for stream_find_replace_all: a directed table of texts and register writes,
// then random texts, every result checked against the table or a find-and-replace predictor.
// Depends on sfr_pkg and the stream_find_replace_all RTL.
module stream_find_replace_all_test;
	import sfr_pkg::*;

	localparam int SETTLE       = 10;
	localparam int RANDOM_ITEMS = 145;
	localparam int QUIET_AFTER  = 120;
	localparam int LONG_HOLD    = 120;
	localparam int HOLD_PHASE   = 4;
	localparam int PAUSE_PHASE  = 2;
	localparam int MAX_REPORTS  = 200;

	typedef enum logic {ROW_CFG, ROW_TEXT} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		logic [CFG_IDX_W-1:0]     idx;
		logic [CFG_DATA_W-1:0]    data;
		in_item_t                 item;
		bit                       typed;
		out_item_t                want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  text_valid;
	logic                  text_stall;
	in_item_t              text_item;
	logic                  result_valid;
	logic                  result_stall;
	out_item_t             result_item;

	// Predictor copy of the block's window and registers
	logic [7:0]  window [MAX_WORD];
	int          fill;
	logic [63:0] pat_word;
	logic [63:0] rep_word;
	logic [3:0]  pat_len_reg;
	logic [3:0]  rep_len_reg;

	out_item_t expected_q[$];
	out_item_t step_out[$];
	stim_row_t rows[$];

	int errors         = 0;
	int texts_accepted = 0;
	int texts_done     = 0;
	int random_items   = 0;
	int results_seen   = 0;
	int cfg_writes     = 0;
	bit quiet          = 0;
	bit hold_req       = 0;
	logic [7:0] letter0 = 8'h61;
	logic [7:0] letter1 = 8'h62;

	stream_find_replace_all dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.text_item    (text_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the run well above the slowest correct case
	initial begin
		#2_000_000;
		$display("Timeout at %0t with %0d results still expected", $time, expected_q.size());
		$display("Test completed with failures");
		$finish;
	end

	function automatic out_item_t mk_out(logic [7:0] b, logic v, logic l);
		out_item_t r;
		r.out_byte   = b;
		r.byte_valid = v;
		r.out_last   = l;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		stim_row_t r;
		r.kind  = ROW_CFG;
		r.idx   = idx;
		r.data  = data;
		r.item  = '0;
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	function automatic stim_row_t text_row(logic [7:0] b, logic l);
		stim_row_t r;
		r.kind         = ROW_TEXT;
		r.idx          = REG_PATTERN_BYTES;
		r.data         = '0;
		r.item.in_byte = b;
		r.item.in_last = l;
		r.typed        = 1'b0;
		r.want         = '0;
		return r;
	endfunction

	function automatic stim_row_t typed_row(logic [7:0] b, logic l, out_item_t want);
		stim_row_t r;
		r       = text_row(b, l);
		r.typed = 1'b1;
		r.want  = want;
		return r;
	endfunction

	function automatic int eff_pat_len();
		int n;
		n = int'(pat_len_reg);
		if (n < 1) n = 1;
		if (n > MAX_WORD) n = MAX_WORD;
		return n;
	endfunction

	function automatic int eff_rep_len();
		int n;
		n = int'(rep_len_reg);
		return (n > REP_MAX) ? REP_MAX : n;
	endfunction

	// Mirror a register write; a new pattern length drops pending bytes
	function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_PATTERN_BYTES: pat_word = data;
			REG_PATTERN_LENGTH: begin
				pat_len_reg = data[3:0];
				fill = 0;
			end
			REG_REPLACEMENT_BYTES: rep_word = data;
			REG_REPLACEMENT_LENGTH: rep_len_reg = data[3:0];
			default: ;
		endcase
	endfunction

	// Advance the window by one text item and collect the results it causes
	function automatic void replace_step(in_item_t it);
		int plen;
		int i;
		bit hit;
		out_item_t tail;
		step_out.delete();
		plen = eff_pat_len();
		if (fill >= plen) fill = plen - 1;
		window[fill] = it.in_byte;
		fill++;
		if (fill == plen) begin
			hit = 1'b1;
			for (i = 0; i < plen; i++)
				if (window[i] !== pat_word[8*i +: 8]) hit = 1'b0;
			if (hit) begin
				for (i = 0; i < eff_rep_len(); i++)
					step_out.push_back(mk_out(rep_word[8*i +: 8], 1'b1, 1'b0));
				fill = 0;
			end else begin
				step_out.push_back(mk_out(window[0], 1'b1, 1'b0));
				for (i = 1; i < fill; i++) window[i-1] = window[i];
				fill--;
			end
		end
		// Flush on the end of the text; a text that ends empty gets a bare marker
		if (it.in_last) begin
			for (i = 0; i < fill; i++) step_out.push_back(mk_out(window[i], 1'b1, 1'b0));
			fill = 0;
			if (step_out.size() == 0) step_out.push_back(mk_out(8'h00, 1'b0, 1'b0));
			tail = step_out.pop_back();
			tail.out_last = 1'b1;
			step_out.push_back(tail);
		end
	endfunction

	// Drop valid and wait until every result is out and the pipeline has drained
	task automatic wait_idle();
		@(negedge clk);
		text_valid = 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		apply_cfg(idx, data);
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Offer one text item, with an occasional gap in front of it
	task automatic send_text(in_item_t it, bit typed, out_item_t want);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				text_valid = 1'b0;
			end
		end
		@(negedge clk);
		text_valid = 1'b1;
		text_item  = it;
		do @(posedge clk); while (text_stall);
		replace_step(it);
		if (typed) expected_q.push_back(want);
		else foreach (step_out[i]) expected_q.push_back(step_out[i]);
		texts_accepted++;
		if (it.in_last) texts_done++;
	endtask

	task automatic check_result(out_item_t got);
		out_item_t w;
		results_seen++;
		if (expected_q.size() == 0) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: unexpected result, expected none, actual byte %h valid %b last %b",
					$time, got.out_byte, got.byte_valid, got.out_last);
		end else begin
			w = expected_q.pop_front();
			if (got.out_byte !== w.out_byte || got.byte_valid !== w.byte_valid ||
					got.out_last !== w.out_last) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: expected byte %h valid %b last %b, actual byte %h valid %b last %b",
						$time, w.out_byte, w.byte_valid, w.out_last,
						got.out_byte, got.byte_valid, got.out_last);
			end
		end
	endtask

	// Pick a new setting, build a text rich in pattern material, then stream it
	task automatic random_phase(int phase);
		int r;
		int nib;
		int k;
		int sel;
		int plen;
		int target;
		int mid;
		logic [63:0] data;
		logic [7:0] txt[$];
		in_item_t it;
		bit [3:0] pick;
		wait_idle();
		pick = 4'($urandom_range(1, 15));
		if (pick[0]) begin
			letter0 = 8'($urandom_range(0, 255));
			letter1 = letter0 ^ (8'h01 << $urandom_range(0, 7));
			data = {$urandom, $urandom};
			if ($urandom_range(0, 1))
				for (k = 0; k < 8; k++) data[8*k +: 8] = $urandom_range(0, 1) ? letter1 : letter0;
			write_reg(REG_PATTERN_BYTES, data);
		end
		if (pick[1]) begin
			r = $urandom_range(0, 9);
			if (r < 5) nib = $urandom_range(1, 3);
			else if (r < 8) nib = $urandom_range(4, 8);
			else if (r == 8) nib = 0;
			else nib = $urandom_range(9, 15);
			data = {$urandom, $urandom};
			data[3:0] = nib[3:0];
			write_reg(REG_PATTERN_LENGTH, data);
		end
		if (pick[2]) begin
			data = {$urandom, $urandom};
			r = $urandom_range(0, 3);
			// A replacement that starts with the pattern must not be rescanned
			if (r == 0) data = pat_word;
			else if (r == 1)
				for (k = 0; k < 8; k++) data[8*k +: 8] = $urandom_range(0, 1) ? letter1 : letter0;
			write_reg(REG_REPLACEMENT_BYTES, data);
		end
		if (pick[3]) begin
			r = $urandom_range(0, 9);
			if (r < 2) nib = 0;
			else if (r < 7) nib = $urandom_range(1, 4);
			else if (r < 9) nib = $urandom_range(5, 8);
			else nib = $urandom_range(9, 15);
			data = {$urandom, $urandom};
			data[3:0] = nib[3:0];
			write_reg(REG_REPLACEMENT_LENGTH, data);
		end

		plen = eff_pat_len();
		if (phase == HOLD_PHASE) target = 40;
		else if (phase == PAUSE_PHASE) target = $urandom_range(6, 14);
		else target = $urandom_range(1, 14);
		while (txt.size() < target) begin
			r = $urandom_range(0, 9);
			if (r < 3) begin
				for (k = 0; k < plen; k++) txt.push_back(pat_word[8*k +: 8]);
			end else if (r < 6) begin
				sel = $urandom_range(0, plen - 1);
				txt.push_back(pat_word[8*sel +: 8]);
			end else if (r < 8) begin
				txt.push_back((r == 6) ? letter0 : letter1);
			end else begin
				txt.push_back(8'($urandom_range(0, 255)));
			end
		end

		// Let the receiver hold off while this long text keeps coming
		if (phase == HOLD_PHASE) hold_req = 1'b1;
		mid = txt.size() / 2;
		for (k = 0; k < txt.size(); k++) begin
			// Halt the text midway until the block has delivered everything
			if (phase == PAUSE_PHASE && k == mid) begin
				@(negedge clk);
				text_valid = 1'b0;
				while (expected_q.size() != 0) @(posedge clk);
			end
			it.in_byte = txt[k];
			it.in_last = (k == txt.size() - 1);
			send_text(it, 1'b0, mk_out(8'h00, 1'b0, 1'b0));
			random_items++;
			if (random_items >= QUIET_AFTER) quiet = 1'b1;
		end
	endtask

	// Result side: check accepted items at the rising edge, set stall at the falling edge
	initial begin : result_side
		int hold;
		int burst;
		bit held;
		hold = 0;
		burst = 0;
		held = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) check_result(result_item);
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				hold--;
				result_stall = 1'b1;
			end else if (burst > 0) begin
				burst--;
				result_stall = 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(0, 7);
				result_stall = 1'b1;
			end else begin
				result_stall = 1'b0;
			end
		end
	end

	initial begin : stimulus
		int phase;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_PATTERN_BYTES;
		cfg_data    = '0;
		text_valid  = 1'b0;
		text_item   = '0;
		pat_word    = '0;
		pat_len_reg = 4'd1;
		rep_word    = '0;
		rep_len_reg = 4'd0;
		fill        = 0;

		// Reset setting: a zero byte is deleted, anything else passes through
		rows.push_back(typed_row(8'h00, 1'b1, mk_out(8'h00, 1'b0, 1'b1)));
		rows.push_back(typed_row(8'hFF, 1'b0, mk_out(8'hFF, 1'b1, 1'b0)));
		rows.push_back(text_row(8'h00, 1'b0));
		rows.push_back(typed_row(8'h5A, 1'b1, mk_out(8'h5A, 1'b1, 1'b1)));
		// Replacement that begins with the pattern
		rows.push_back(cfg_row(REG_PATTERN_BYTES, 64'h6261));
		rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'h2));
		rows.push_back(cfg_row(REG_REPLACEMENT_BYTES, 64'h6261_6261));
		rows.push_back(cfg_row(REG_REPLACEMENT_LENGTH, 64'h4));
		rows.push_back(text_row(8'h78, 1'b0));
		rows.push_back(text_row(8'h61, 1'b0));
		rows.push_back(text_row(8'h62, 1'b0));
		rows.push_back(text_row(8'h61, 1'b0));
		rows.push_back(text_row(8'h62, 1'b0));
		rows.push_back(text_row(8'h61, 1'b1));
		// Rewriting the pattern length mid text drops the pending byte
		rows.push_back(text_row(8'h61, 1'b0));
		rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'h2));
		rows.push_back(text_row(8'h62, 1'b1));
		// Pattern length zero acts as one
		rows.push_back(cfg_row(REG_PATTERN_BYTES, 64'h41));
		rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'h0));
		rows.push_back(cfg_row(REG_REPLACEMENT_BYTES, 64'h7A));
		rows.push_back(cfg_row(REG_REPLACEMENT_LENGTH, 64'h1));
		rows.push_back(typed_row(8'h41, 1'b1, mk_out(8'h7A, 1'b1, 1'b1)));
		// Oversized lengths clamp to eight: full window of ones, eight results
		rows.push_back(cfg_row(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF));
		rows.push_back(cfg_row(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF));
		rows.push_back(cfg_row(REG_REPLACEMENT_BYTES, 64'h0001_7F80_FE55_AA00));
		rows.push_back(cfg_row(REG_REPLACEMENT_LENGTH, 64'hA5A5_A5A5_A5A5_A5AC));
		repeat (8) rows.push_back(text_row(8'hFF, 1'b0));
		repeat (3) rows.push_back(text_row(8'hFF, 1'b0));
		rows.push_back(text_row(8'h00, 1'b1));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(rows[i].idx, rows[i].data);
			end else begin
				send_text(rows[i].item, rows[i].typed, rows[i].want);
			end
		end

		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			random_phase(phase);
			phase++;
		end

		// Drain and give late results a chance to show
		@(negedge clk);
		text_valid = 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Streamed %0d text items over %0d texts and %0d settings phases",
			texts_accepted, texts_done, phase);
		$display("Checked %0d result items after %0d register writes", results_seen, cfg_writes);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== stream_find_replace_all.f =====
rtl/sfr_pkg.sv
rtl/sfr_front.sv
rtl/sfr_queue.sv
rtl/sfr_back.sv
rtl/stream_find_replace_all.sv
verif/stream_find_replace_all_test.sv
